### rtl/ltsl_pkg.sv
// shared types and constants for the line token span lexer
package ltsl_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 32;
   localparam int MAX_DEPTH_DEFAULT    = 255;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_EOL  = 1'b1;

   localparam logic KIND_TOKEN = 1'b0;
   localparam logic KIND_LINE  = 1'b1;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0d;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_PLAIN   = 3'd1,
      MODE_QUOTE   = 3'd2,
      MODE_DOLLAR  = 3'd3,
      MODE_EXPR    = 3'd4,
      MODE_COMMENT = 3'd5
   } lex_mode_type;

endpackage

### rtl/line_token_span_lexer_core.sv
// line token span lexer: splits a byte stream into token and line end spans
//
// Takes one request per clock (a line byte with its offset, or an end-of-line
// mark) and updates the lexer state in the same cycle. Each request gives zero,
// one or two responses, which go into a four-entry response queue; rsp_ready
// low only stalls the request side once the queue holds more than two entries,
// so with the response side ready the block sustains one request per cycle.
// A byte yields at most one token span; an end-of-line mark yields the pending
// token span, if any, then the line record, marked with last. Offsets wrap
// at OFFSET_WIDTH bits and the $( ) nesting depth saturates at MAX_DEPTH.
module line_token_span_lexer_core #(
   parameter int OFFSET_WIDTH = ltsl_pkg::OFFSET_WIDTH_DEFAULT,
   parameter int MAX_DEPTH    = ltsl_pkg::MAX_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [7:0]              req_ch,
   input  logic [OFFSET_WIDTH-1:0] req_offset,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic [OFFSET_WIDTH-1:0] rsp_span_begin,
   output logic [OFFSET_WIDTH-1:0] rsp_span_end,
   output logic                    rsp_is_symbolic,
   output logic                    rsp_has_comment,
   output logic                    rsp_last
);

   localparam int DEPTH_WIDTH = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = DEPTH_WIDTH'(MAX_DEPTH);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE = DEPTH_WIDTH'(1);
   localparam logic [DEPTH_WIDTH-1:0] DEPTH_ZERO = '0;
   localparam logic [OFFSET_WIDTH-1:0] OFFSET_ONE = OFFSET_WIDTH'(1);
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] CNT_ROOM = CNT_WIDTH'(QUEUE_DEPTH - 2);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0] PTR_ONE = PTR_WIDTH'(1);

   // lexer line state
   ltsl_pkg::lex_mode_type mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0] token_begin_ff, token_begin_in;
   logic                    symbolic_seen_ff, symbolic_seen_in;
   logic [DEPTH_WIDTH-1:0]  paren_depth_ff, paren_depth_in;
   logic [OFFSET_WIDTH-1:0] comment_begin_ff, comment_begin_in;
   logic                    comment_seen_ff, comment_seen_in;

   // response queue
   logic                    q_kind_ff     [QUEUE_DEPTH];
   logic [OFFSET_WIDTH-1:0] q_begin_ff    [QUEUE_DEPTH];
   logic [OFFSET_WIDTH-1:0] q_end_ff      [QUEUE_DEPTH];
   logic                    q_symbolic_ff [QUEUE_DEPTH];
   logic                    q_comment_ff  [QUEUE_DEPTH];
   logic                    q_last_ff     [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]    count_ff, count_in;

   logic req_fire, rsp_fire, is_sep, depth_dec_zero;
   logic [DEPTH_WIDTH-1:0]  depth_after_close;
   logic [OFFSET_WIDTH-1:0] offset_next;
   logic [1:0]              num_res;

   logic                    r0_kind, r1_kind;
   logic [OFFSET_WIDTH-1:0] r0_begin, r0_end, r1_begin, r1_end;
   logic                    r0_symbolic, r0_comment, r0_last;
   logic                    r1_symbolic, r1_comment, r1_last;

   assign req_ready = (count_ff <= CNT_ROOM);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign is_sep = req_ch inside {ltsl_pkg::CH_SPACE, ltsl_pkg::CH_TAB, ltsl_pkg::CH_CR};
   assign offset_next = req_offset + OFFSET_ONE;
   assign depth_after_close = (paren_depth_ff != DEPTH_ZERO) ?
                              paren_depth_ff - DEPTH_ONE : DEPTH_ZERO;
   assign depth_dec_zero = (depth_after_close == DEPTH_ZERO);

   // next line state
   always_comb begin
      mode_in          = mode_ff;
      token_begin_in   = token_begin_ff;
      symbolic_seen_in = symbolic_seen_ff;
      paren_depth_in   = paren_depth_ff;
      comment_begin_in = comment_begin_ff;
      comment_seen_in  = comment_seen_ff;
      if (req_cmd == ltsl_pkg::CMD_EOL) begin
         mode_in          = ltsl_pkg::MODE_IDLE;
         token_begin_in   = '0;
         symbolic_seen_in = 1'b0;
         paren_depth_in   = DEPTH_ZERO;
         comment_begin_in = '0;
         comment_seen_in  = 1'b0;
      end else begin
         case (mode_ff)
            ltsl_pkg::MODE_PLAIN: begin
               if (is_sep) begin
                  mode_in = ltsl_pkg::MODE_IDLE;
               end else if (req_ch == ltsl_pkg::CH_DOLLAR) begin
                  symbolic_seen_in = 1'b1;
               end
            end
            ltsl_pkg::MODE_DOLLAR: begin
               if (req_ch == ltsl_pkg::CH_LPAREN) begin
                  mode_in        = ltsl_pkg::MODE_EXPR;
                  paren_depth_in = DEPTH_ONE;
               end else if (is_sep) begin
                  mode_in = ltsl_pkg::MODE_IDLE;
               end else begin
                  mode_in = ltsl_pkg::MODE_PLAIN;
               end
            end
            ltsl_pkg::MODE_QUOTE: begin
               if (req_ch == ltsl_pkg::CH_QUOTE) begin
                  mode_in = ltsl_pkg::MODE_IDLE;
               end
            end
            ltsl_pkg::MODE_EXPR: begin
               if (req_ch == ltsl_pkg::CH_LPAREN) begin
                  if (paren_depth_ff < DEPTH_MAX) begin
                     paren_depth_in = paren_depth_ff + DEPTH_ONE;
                  end
               end else if (req_ch == ltsl_pkg::CH_RPAREN) begin
                  paren_depth_in = depth_after_close;
                  if (depth_dec_zero) begin
                     mode_in = ltsl_pkg::MODE_IDLE;
                  end
               end
            end
            ltsl_pkg::MODE_COMMENT: begin
            end
            default: begin
               if (is_sep) begin
               end else if (req_ch == ltsl_pkg::CH_HASH) begin
                  comment_begin_in = req_offset;
                  comment_seen_in  = 1'b1;
                  mode_in          = ltsl_pkg::MODE_COMMENT;
               end else begin
                  token_begin_in = req_offset;
                  paren_depth_in = DEPTH_ZERO;
                  if (req_ch == ltsl_pkg::CH_QUOTE) begin
                     mode_in          = ltsl_pkg::MODE_QUOTE;
                     symbolic_seen_in = 1'b0;
                  end else if (req_ch == ltsl_pkg::CH_DOLLAR) begin
                     mode_in          = ltsl_pkg::MODE_DOLLAR;
                     symbolic_seen_in = 1'b1;
                  end else begin
                     mode_in          = ltsl_pkg::MODE_PLAIN;
                     symbolic_seen_in = 1'b0;
                  end
               end
            end
         endcase
      end
   end

   // responses caused by this request
   always_comb begin
      num_res     = 2'd0;
      r0_kind     = ltsl_pkg::KIND_TOKEN;
      r0_begin    = token_begin_ff;
      r0_end      = req_offset;
      r0_symbolic = symbolic_seen_ff;
      r0_comment  = 1'b0;
      r0_last     = 1'b1;
      r1_kind     = ltsl_pkg::KIND_LINE;
      r1_begin    = comment_seen_ff ? comment_begin_ff : req_offset;
      r1_end      = req_offset;
      r1_symbolic = 1'b0;
      r1_comment  = comment_seen_ff;
      r1_last     = 1'b1;
      if (req_cmd == ltsl_pkg::CMD_EOL) begin
         if (mode_ff inside {ltsl_pkg::MODE_PLAIN, ltsl_pkg::MODE_QUOTE,
                             ltsl_pkg::MODE_DOLLAR, ltsl_pkg::MODE_EXPR}) begin
            num_res = 2'd2;
            r0_last = 1'b0;
         end else begin
            // line record alone goes in the first slot
            num_res     = 2'd1;
            r0_kind     = r1_kind;
            r0_begin    = r1_begin;
            r0_symbolic = 1'b0;
            r0_comment  = r1_comment;
         end
      end else begin
         case (mode_ff)
            ltsl_pkg::MODE_PLAIN: begin
               if (is_sep) begin
                  num_res = 2'd1;
               end
            end
            ltsl_pkg::MODE_DOLLAR: begin
               if (req_ch != ltsl_pkg::CH_LPAREN && is_sep) begin
                  num_res     = 2'd1;
                  r0_symbolic = 1'b1;
               end
            end
            ltsl_pkg::MODE_QUOTE: begin
               if (req_ch == ltsl_pkg::CH_QUOTE) begin
                  num_res     = 2'd1;
                  r0_end      = offset_next;
                  r0_symbolic = 1'b0;
               end
            end
            ltsl_pkg::MODE_EXPR: begin
               if (req_ch == ltsl_pkg::CH_RPAREN && depth_dec_zero) begin
                  num_res     = 2'd1;
                  r0_end      = offset_next;
                  r0_symbolic = 1'b1;
               end
            end
            default: begin
               num_res = 2'd0;
            end
         endcase
      end
   end

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(num_res);
         count_in  = count_ff + CNT_WIDTH'(num_res);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + PTR_ONE;
         count_in  = count_in - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= ltsl_pkg::MODE_IDLE;
         token_begin_ff   <= '0;
         symbolic_seen_ff <= 1'b0;
         paren_depth_ff   <= DEPTH_ZERO;
         comment_begin_ff <= '0;
         comment_seen_ff  <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (req_fire) begin
            mode_ff          <= mode_in;
            token_begin_ff   <= token_begin_in;
            symbolic_seen_ff <= symbolic_seen_in;
            paren_depth_ff   <= paren_depth_in;
            comment_begin_ff <= comment_begin_in;
            comment_seen_ff  <= comment_seen_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && num_res != 2'd0) begin
         q_kind_ff[wr_ptr_ff]     <= r0_kind;
         q_begin_ff[wr_ptr_ff]    <= r0_begin;
         q_end_ff[wr_ptr_ff]      <= r0_end;
         q_symbolic_ff[wr_ptr_ff] <= r0_symbolic;
         q_comment_ff[wr_ptr_ff]  <= r0_comment;
         q_last_ff[wr_ptr_ff]     <= r0_last;
      end
      if (req_fire && num_res == 2'd2) begin
         q_kind_ff[wr_ptr_ff + PTR_ONE]     <= r1_kind;
         q_begin_ff[wr_ptr_ff + PTR_ONE]    <= r1_begin;
         q_end_ff[wr_ptr_ff + PTR_ONE]      <= r1_end;
         q_symbolic_ff[wr_ptr_ff + PTR_ONE] <= r1_symbolic;
         q_comment_ff[wr_ptr_ff + PTR_ONE]  <= r1_comment;
         q_last_ff[wr_ptr_ff + PTR_ONE]     <= r1_last;
      end
   end

   assign rsp_kind        = q_kind_ff[rd_ptr_ff];
   assign rsp_span_begin  = q_begin_ff[rd_ptr_ff];
   assign rsp_span_end    = q_end_ff[rd_ptr_ff];
   assign rsp_is_symbolic = q_symbolic_ff[rd_ptr_ff];
   assign rsp_has_comment = q_comment_ff[rd_ptr_ff];
   assign rsp_last        = q_last_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   // nesting depth is only held while inside a $( ) expression
   a_depth_expr: assert property (@(posedge clock) disable iff (reset)
      (paren_depth_ff != DEPTH_ZERO) == (mode_ff == ltsl_pkg::MODE_EXPR))
      else $error("paren depth out of step with lexer mode");

   a_comment_mode: assert property (@(posedge clock) disable iff (reset)
      comment_seen_ff == (mode_ff == ltsl_pkg::MODE_COMMENT))
      else $error("comment flag out of step with lexer mode");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == ltsl_pkg::CMD_EOL |=>
         mode_ff == ltsl_pkg::MODE_IDLE && !comment_seen_ff && count_ff != '0)
      else $error("end of line did not clear line state or queue a record");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("response queue overflow");
`endif

endmodule
